// File: rtl/ardt_pkg.sv
// Shared types and constants for the approximate record dedup table.
package ardt_pkg;

  localparam int TableDepth = 4096;
  localparam int IndexWidth = 13;
  localparam int TolReset = 4;
  localparam int LimitReset = 4096;
  localparam logic [7:0] AngleWrap = 8'd255;

  typedef enum logic [0:0] {
    CfgTolerance = 1'b0,
    CfgTableLimit = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic start_new_set;
    logic [31:0] styles;
    logic [7:0] latitude;
    logic [7:0] longitude;
    logic [63:0] ambient_low;
    logic [31:0] ambient_high;
    logic [63:0] directed_low;
    logic [31:0] directed_high;
  } in_item_t;

  typedef struct packed {
    logic [IndexWidth-1:0] entry_index;
    logic was_added;
    logic full_miss;
  } out_item_t;

  // Stored form: 48-bit header plus four 48-bit colour words.
  typedef struct packed {
    logic start_new_set;
    logic [47:0] hdr;
    logic [191:0] col;
  } rec_t;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StCheck,
    StDone
  } state_t;

  function automatic logic byte_ok(logic [7:0] a, logic [7:0] b, logic [7:0] tol);
    logic [7:0] d;
    d = (a > b) ? a - b : b - a;
    return d <= tol;
  endfunction

  function automatic logic angle_ok(logic [7:0] a, logic [7:0] b, logic [7:0] tol);
    logic [7:0] d;
    d = (a > b) ? a - b : b - a;
    return (d <= tol) || (d >= AngleWrap - tol);
  endfunction

  function automatic rec_t pack_rec(in_item_t it);
    rec_t r;
    r.start_new_set = it.start_new_set;
    r.hdr = {it.longitude, it.latitude, it.styles};
    r.col = {it.directed_high, it.directed_low[63:48], it.directed_low[47:0],
             it.ambient_high, it.ambient_low[63:48], it.ambient_low[47:0]};
    return r;
  endfunction

endpackage

// File: rtl/ardt_front.sv
// Front stage: packs accepted items into stored form and queues them.
module ardt_front (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  ardt_pkg::in_item_t in_item,
  output logic q_valid,
  input  logic q_take,
  output ardt_pkg::rec_t q_rec
);
  ardt_pkg::rec_t slot [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] cnt;

  assign full = cnt == 2'd2;
  assign q_valid = cnt != 2'd0;
  assign q_rec = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot[wr_ptr] <= ardt_pkg::pack_rec(in_item);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (q_take && q_valid) rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'((push && !full) ? 1 : 0) - 2'((q_take && q_valid) ? 1 : 0);
    end
  end
endmodule

// File: rtl/ardt_back.sv
// Back stage: scans the table one stored record per cycle and appends misses while below the limit.
module ardt_back #(
  parameter int TABLE_DEPTH = ardt_pkg::TableDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic [7:0] tolerance,
  input  logic [12:0] table_limit,
  input  logic q_valid,
  output logic q_take,
  input  ardt_pkg::rec_t q_rec,
  output logic res_valid,
  input  logic res_take,
  output ardt_pkg::out_item_t res
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [47:0] hdr_mem [TABLE_DEPTH];
  logic [191:0] col_mem [TABLE_DEPTH];
  logic [47:0] hdr_rd;
  logic [191:0] col_rd;

  ardt_pkg::state_t state, state_next;
  logic [CW-1:0] count, count_next, idx, idx_next;
  ardt_pkg::rec_t cur;
  logic hit;
  logic [CW-1:0] limit;
  logic wr_en, rd_en, out_load;
  ardt_pkg::out_item_t res_next;

  assign limit = ({3'b0, table_limit} < 16'(TABLE_DEPTH)) ? CW'(table_limit)
                                                           : CW'(TABLE_DEPTH);

  always_comb begin
    hit = hdr_rd[31:0] == cur.hdr[31:0]
       && ardt_pkg::angle_ok(cur.hdr[39:32], hdr_rd[39:32], tolerance)
       && ardt_pkg::angle_ok(cur.hdr[47:40], hdr_rd[47:40], tolerance);
    for (int b = 0; b < 24; b++) begin
      if (!ardt_pkg::byte_ok(cur.col[8*b +: 8], col_rd[8*b +: 8], tolerance)) hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      hdr_rd <= hdr_mem[idx_next[AW-1:0]];
      col_rd <= col_mem[idx_next[AW-1:0]];
    end
    if (wr_en) begin
      hdr_mem[count[AW-1:0]] <= cur.hdr;
      col_mem[count[AW-1:0]] <= cur.col;
    end
    if (q_take) cur <= q_rec;
    if (out_load) res <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ardt_pkg::StIdle;
      count <= '0;
      idx <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      idx <= idx_next;
      if (out_load) res_valid <= 1'b1;
      else if (res_take) res_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next = idx;
    q_take = 1'b0;
    rd_en = 1'b0;
    wr_en = 1'b0;
    out_load = 1'b0;
    res_next = '0;
    case (state)
      ardt_pkg::StIdle: begin
        if (q_valid) begin
          q_take = 1'b1;
          idx_next = '0;
          if (q_rec.start_new_set) count_next = '0;
          state_next = ardt_pkg::StRead;
        end
      end
      ardt_pkg::StRead: begin
        if (idx < count) begin
          rd_en = 1'b1;
          state_next = ardt_pkg::StCheck;
        end else begin
          state_next = ardt_pkg::StDone;
        end
      end
      ardt_pkg::StCheck: begin
        if (hit) begin
          if (!res_valid || res_take) begin
            out_load = 1'b1;
            res_next.entry_index = 13'(idx);
            state_next = ardt_pkg::StIdle;
          end
        end else begin
          // advance and fetch the next record in the same cycle
          idx_next = idx + 1'b1;
          if (idx + 1'b1 < count) begin
            rd_en = 1'b1;
            idx_next = idx + 1'b1;
          end else begin
            state_next = ardt_pkg::StDone;
          end
        end
      end
      ardt_pkg::StDone: begin
        if (!res_valid || res_take) begin
          out_load = 1'b1;
          res_next.entry_index = 13'(count);
          if (count < limit) begin
            wr_en = 1'b1;
            count_next = count + 1'b1;
            res_next.was_added = 1'b1;
          end else begin
            res_next.full_miss = 1'b1;
          end
          state_next = ardt_pkg::StIdle;
        end
      end
      default: state_next = ardt_pkg::StIdle;
    endcase
  end
endmodule

// File: rtl/approximate_record_dedup_table_core.sv
// Top level of the approximate record dedup table.
// Input queue: raise push with an item while full is low; the item is taken
// at that edge. A two-deep queue holds items while the search runs.
// Result register: while empty is low the held result is on the result ports;
// pop at an edge with empty low takes it. A full result holds the search.
// Config: cfg_valid/cfg_ready with cfg_index (0 tolerance, 1 table_limit)
// and cfg_data; ready is always high. Write only while idle.
// Search: the back stage compares one stored record per cycle out of the
// table memory, reading each record in Read or Check and comparing it in
// Check; a miss ends in Done, which appends it if the table is below its
// limit, and a hit ends the scan at its index. Items are searched one at a
// time: the next item leaves the queue only after the last search ends.
// Reset clears the record count, queues and registers (tolerance 4,
// table_limit 4096); the table memory needs no clearing pass.
// start_new_set on an item empties the table before that item is searched.
module approximate_record_dedup_table_core #(
  parameter int TABLE_DEPTH = ardt_pkg::TableDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  ardt_pkg::in_item_t in_item,
  output logic empty,
  input  logic pop,
  output ardt_pkg::out_item_t out_item,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [12:0] cfg_data
);
  logic [7:0] tolerance;
  logic [12:0] table_limit;
  logic q_valid, q_take, res_valid;
  ardt_pkg::rec_t q_rec;

  assign cfg_ready = 1'b1;
  assign empty = !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= 8'(ardt_pkg::TolReset);
      table_limit <= 13'(ardt_pkg::LimitReset);
    end else if (cfg_valid) begin
      if (cfg_index == 2'(ardt_pkg::CfgTolerance)) tolerance <= cfg_data[7:0];
      else if (cfg_index == 2'(ardt_pkg::CfgTableLimit)) table_limit <= cfg_data;
    end
  end

  ardt_front u_front (
    .clk, .rst, .push, .full, .in_item,
    .q_valid, .q_take, .q_rec
  );

  ardt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk, .rst, .tolerance, .table_limit,
    .q_valid, .q_take, .q_rec,
    .res_valid, .res_take(pop), .res(out_item)
  );
endmodule

// File: rtl/ardt_checker.sv
// Port-level checks for the dedup table, bound to the top level.
module ardt_checker (
  input logic clk,
  input logic rst,
  input logic full,
  input logic empty,
  input logic pop,
  input ardt_pkg::out_item_t out_item
);
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(out_item.was_added && out_item.full_miss))
    else $error("added and full miss together");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("result changed while stalled");
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (empty && !full))
    else $error("not empty after reset");
  a_result_known: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !$isunknown(out_item))
    else $error("result has unknown bits");
endmodule

bind approximate_record_dedup_table_core ardt_checker u_ardt_checker (
  .clk, .rst, .full, .empty, .pop, .out_item
);
